[src/log_ramp_velocity_ratio_macros.svh]
// assertion macros for the logarithmic velocity ramp
// used by log_ramp_velocity_ratio.sv, expects clk and arst_n in scope
`ifndef LOG_RAMP_VELOCITY_RATIO_MACROS_SVH
`define LOG_RAMP_VELOCITY_RATIO_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LRVR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define LRVR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lrvr_pkg.sv]
// package for the logarithmic velocity ramp: codes, constants, log step
// no dependencies
package lrvr_pkg;

	typedef enum logic [1:0] {
		LB_LOAD,
		LB_RUN,
		LB_DONE
	} lb_state_t;

	typedef enum logic [2:0] {
		REG_LOWER_THRESHOLD = 3'd0,
		REG_UPPER_THRESHOLD = 3'd1,
		REG_LOWER_RATIO     = 3'd2,
		REG_UPPER_RATIO     = 3'd3,
		REG_MINIMUM_RATIO   = 3'd4,
		REG_LOG_BASE        = 3'd5
	} reg_idx_t;

	localparam logic [1:0] REGION_LOW  = 2'd0;
	localparam logic [1:0] REGION_LOG  = 2'd1;
	localparam logic [1:0] REGION_HIGH = 2'd2;

	localparam int LOG_FRAC  = 24;
	localparam int MANT_FRAC = 30;
	localparam int LN_W      = 28;

	localparam logic [15:0] BASE_ONE     = 16'd256;
	localparam logic [15:0] DEFAULT_BASE = 16'd2560;

	// one squaring round of the log2 mantissa, returns {bit, new mantissa}
	function automatic logic [31:0] log_round(input logic [30:0] m);
		logic [61:0] sq;
		logic [31:0] t;
		sq = 62'(m) * 62'(m);
		t  = sq[61:30];
		if (t[31])
			log_round = {1'b1, t[31:1]};
		else
			log_round = {1'b0, t[30:0]};
	endfunction

endpackage

[src/log_ramp_velocity_ratio.sv]
// logarithmic velocity ramp, top level: distance ratio in, velocity ratio out
// depends on lrvr_pkg and log_ramp_velocity_ratio_macros.svh
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | gap_ratio
//  output   | out_valid / out_ready| velocity_ratio, region
//  config   | cfg_we               | cfg_idx, cfg_wdata
//
// one word per cycle sustained while out_ready is high and the base log is
// done; the pipe holds the 32 bit span divider, 24 squaring rounds and the log divider
// after reset and after each config write a sequencer recomputes log2 of
// the base; in_ready is low meanwhile
// per-stage valid bits, each stage loads when it is empty or moves on, so
// a stall on the output fills bubbles and loses nothing
`include "log_ramp_velocity_ratio_macros.svh"

module log_ramp_velocity_ratio #(
	parameter int RATIO_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] gap_ratio,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] velocity_ratio,
	output logic [1:0]  region,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	import lrvr_pkg::*;

	// widths
	localparam int ONE_W  = RATIO_FRAC_BITS + 1;
	localparam int CW     = (ONE_W > 17) ? ONE_W : 17;
	localparam int QB     = RATIO_FRAC_BITS + 2;
	localparam int NUMW   = LN_W + ONE_W;
	localparam int VW     = QB + 1;
	localparam int OW     = (VW > 16) ? VW : 16;
	localparam int SIDE_W = 2 + 3 * ONE_W;

	// stage numbering
	localparam int K_D1   = 2;
	localparam int K_D1E  = 17;
	localparam int K_NORM = 18;
	localparam int K_LOG  = 19;
	localparam int K_LOGE = 42;
	localparam int K_MUL  = 43;
	localparam int K_PREP = 44;
	localparam int K_D2   = 45;
	localparam int D2     = (QB + 1) / 2;
	localparam int N_STG  = K_D2 + D2;

	localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1} << RATIO_FRAC_BITS;

	// configuration registers
	logic [15:0] lo_thr_q, hi_thr_q, lo_rat_q, hi_rat_q, min_rat_q, base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_thr_q  <= 16'd0;
			hi_thr_q  <= 16'd32768;
			lo_rat_q  <= 16'd0;
			hi_rat_q  <= 16'd32768;
			min_rat_q <= 16'd0;
			base_q    <= DEFAULT_BASE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LOWER_THRESHOLD: lo_thr_q  <= cfg_wdata;
				REG_UPPER_THRESHOLD: hi_thr_q  <= cfg_wdata;
				REG_LOWER_RATIO:     lo_rat_q  <= cfg_wdata;
				REG_UPPER_RATIO:     hi_rat_q  <= cfg_wdata;
				REG_MINIMUM_RATIO:   min_rat_q <= cfg_wdata;
				REG_LOG_BASE:        base_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a base at or below 1.0 falls back to 10.0
	logic [15:0] base_eff;
	assign base_eff = (base_q <= BASE_ONE) ? DEFAULT_BASE : base_q;

	// sequencer for log2 of the base
	lb_state_t       lb_state_q, lb_state_d;
	logic [30:0]     lb_m_q, lb_m_d;
	logic [LN_W-1:0] lb_acc_q, lb_acc_d;
	logic [4:0]      lb_cnt_q, lb_cnt_d;
	logic [3:0]      lb_p;
	logic [45:0]     lb_w;
	logic [31:0]     lb_r;
	logic            lb_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_state_q <= LB_LOAD;
			lb_m_q     <= '0;
			lb_acc_q   <= '0;
			lb_cnt_q   <= '0;
		end else begin
			lb_state_q <= lb_state_d;
			lb_m_q     <= lb_m_d;
			lb_acc_q   <= lb_acc_d;
			lb_cnt_q   <= lb_cnt_d;
		end
	end

	always_comb begin
		lb_state_d = lb_state_q;
		lb_m_d     = lb_m_q;
		lb_acc_d   = lb_acc_q;
		lb_cnt_d   = lb_cnt_q;
		lb_p       = '0;
		lb_w       = '0;
		lb_r       = log_round(lb_m_q);
		unique case (lb_state_q)
			LB_LOAD: begin
				// leading one gives the integer part, mantissa to Q1.30
				for (int i = 0; i < 16; i++)
					if (base_eff[i])
						lb_p = 4'(i);
				lb_w       = {base_eff, 30'd0} >> lb_p;
				lb_m_d     = lb_w[30:0];
				lb_acc_d   = {1'b0, 3'(lb_p - 4'd8), 24'd0};
				lb_cnt_d   = 5'(LOG_FRAC - 1);
				lb_state_d = LB_RUN;
			end
			LB_RUN: begin
				lb_m_d           = lb_r[30:0];
				lb_acc_d[lb_cnt_q] = lb_r[31];
				if (lb_cnt_q == 5'd0)
					lb_state_d = LB_DONE;
				else
					lb_cnt_d = lb_cnt_q - 5'd1;
			end
			LB_DONE: ;
			default: lb_state_d = LB_LOAD;
		endcase
		if (cfg_we)
			lb_state_d = LB_LOAD;
	end

	assign lb_done = (lb_state_q == LB_DONE);

	// valid bits and the ready chain
	logic             v_q [1:N_STG];
	logic [1:N_STG+1] en;

	assign en[N_STG+1] = out_ready;
	for (genvar k = 1; k <= N_STG; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	assign in_ready = en[1] && lb_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= N_STG; k++)
				v_q[k] <= 1'b0;
		end else begin
			if (en[1])
				v_q[1] <= in_valid && in_ready;
			for (int k = 2; k <= N_STG; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	// side band carried down the pipe: {region, fixed value, rl, ru - rl}
	logic [SIDE_W-1:0] side_s [1:N_STG-1];

	for (genvar k = 2; k <= N_STG - 1; k++) begin : g_side
		always_ff @(posedge clk)
			if (en[k])
				side_s[k] <= side_s[k-1];
	end

	// stage 1: clean up the config, classify, form the span dividend
	logic [CW-1:0] lo_x, hi_x, rl_x, ru_x, min_x, d_x, span_c;
	logic          thr_bad, rat_bad;
	logic [1:0]    reg_c;
	logic [15:0]   diff_c, bm_c;
	logic [31:0]   prod_c;
	logic [CW-1:0] vfix_c;

	always_comb begin
		lo_x    = CW'(lo_thr_q);
		hi_x    = CW'(hi_thr_q);
		thr_bad = (hi_x <= lo_x) || (hi_x > ONE_C) || (lo_x > ONE_C);
		if (thr_bad) begin
			lo_x = '0;
			hi_x = ONE_C;
		end
		rl_x    = CW'(lo_rat_q);
		ru_x    = CW'(hi_rat_q);
		rat_bad = (ru_x <= rl_x) || (ru_x > ONE_C) || (rl_x > ONE_C);
		if (rat_bad) begin
			rl_x = '0;
			ru_x = ONE_C;
		end
		min_x = CW'(min_rat_q);
		if (min_x > ONE_C)
			min_x = ONE_C;
		d_x = CW'(gap_ratio);
		if (d_x > hi_x)
			reg_c = REGION_HIGH;
		else if (d_x > lo_x)
			reg_c = REGION_LOG;
		else
			reg_c = REGION_LOW;
		vfix_c = (reg_c == REGION_HIGH) ? ru_x : min_x;
		diff_c = 16'(d_x - lo_x);
		bm_c   = base_eff - BASE_ONE;
		prod_c = 32'(diff_c) * 32'(bm_c);
		span_c = hi_x - lo_x;
	end

	// span divider: {a, q} is a restoring divider, two quotient bits a stage
	logic [CW-1:0] a1_s    [1:K_D1E];
	logic [31:0]   q1_s    [1:K_D1E];
	logic [CW-1:0] span1_s [1:K_D1E];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s[1]  <= {reg_c, ONE_W'(vfix_c), ONE_W'(rl_x), ONE_W'(ru_x - rl_x)};
			a1_s[1]    <= CW'(prod_c[31:16]);
			q1_s[1]    <= {prod_c[15:0], 16'd0};
			span1_s[1] <= span_c;
		end
	end

	for (genvar k = K_D1; k <= K_D1E; k++) begin : g_div1
		logic [CW-1:0] a_c;
		logic [31:0]   q_c;
		always_comb begin
			logic [CW:0] t;
			a_c = a1_s[k-1];
			q_c = q1_s[k-1];
			for (int s = 0; s < 2; s++) begin
				t   = {a_c, q_c[31]};
				q_c = {q_c[30:0], 1'b0};
				if (t >= {1'b0, span1_s[k-1]}) begin
					a_c    = CW'(t - {1'b0, span1_s[k-1]});
					q_c[0] = 1'b1;
				end else begin
					a_c = t[CW-1:0];
				end
			end
		end
		always_ff @(posedge clk)
			if (en[k]) begin
				a1_s[k]    <= a_c;
				q1_s[k]    <= q_c;
				span1_s[k] <= span1_s[k-1];
			end
	end

	// normalize n = 1.0 + quotient (Q8.24) to a Q1.30 mantissa
	logic [30:0]     lm_s   [K_NORM:K_LOGE];
	logic [LN_W-1:0] lacc_s [K_NORM:K_LOGE];
	logic [32:0]     n_c;
	logic [5:0]      np_c;
	logic [62:0]     nw_c;

	always_comb begin
		n_c  = 33'(q1_s[K_D1E]) + (33'd1 << LOG_FRAC);
		np_c = '0;
		for (int i = 0; i < 33; i++)
			if (n_c[i])
				np_c = 6'(i);
		nw_c = {n_c, 30'd0} >> np_c;
	end

	always_ff @(posedge clk)
		if (en[K_NORM]) begin
			lm_s[K_NORM]   <= nw_c[30:0];
			lacc_s[K_NORM] <= {4'(np_c - 6'd24), 24'd0};
		end

	// squaring rounds, one fraction bit of log2(n) per stage
	for (genvar k = K_LOG; k <= K_LOGE; k++) begin : g_log
		localparam int POS = LOG_FRAC - 1 - (k - K_LOG);
		logic [31:0]     r_c;
		logic [LN_W-1:0] acc_c;
		always_comb begin
			r_c        = log_round(lm_s[k-1]);
			acc_c      = lacc_s[k-1];
			acc_c[POS] = r_c[31];
		end
		always_ff @(posedge clk)
			if (en[k]) begin
				lm_s[k]   <= r_c[30:0];
				lacc_s[k] <= acc_c;
			end
	end

	// log2(n) * (ru - rl)
	logic [NUMW-1:0] mp_s43;

	always_ff @(posedge clk)
		if (en[K_MUL])
			mp_s43 <= NUMW'(lacc_s[K_LOGE]) * NUMW'(side_s[K_LOGE][ONE_W-1:0]);

	// log divider: quotient over QB bits, an overflow flag saturates
	logic [LN_W-1:0] a2_s   [K_PREP:N_STG-1];
	logic [QB-1:0]   q2_s   [K_PREP:N_STG-1];
	logic            ovf_s  [K_PREP:N_STG-1];

	always_ff @(posedge clk)
		if (en[K_PREP]) begin
			a2_s[K_PREP]  <= LN_W'(mp_s43 >> QB);
			q2_s[K_PREP]  <= mp_s43[QB-1:0];
			ovf_s[K_PREP] <= (mp_s43 >> QB) >= NUMW'(lb_acc_q);
		end

	for (genvar k = K_D2; k <= N_STG - 1; k++) begin : g_div2
		localparam int BASE = 2 * (k - K_D2);
		logic [LN_W-1:0] a_c;
		logic [QB-1:0]   q_c;
		always_comb begin
			logic [LN_W:0] t;
			a_c = a2_s[k-1];
			q_c = q2_s[k-1];
			t   = '0;
			for (int s = 0; s < 2; s++) begin
				if (BASE + s < QB) begin
					t   = {a_c, q_c[QB-1]};
					q_c = {q_c[QB-2:0], 1'b0};
					if (t >= {1'b0, lb_acc_q}) begin
						a_c    = LN_W'(t - {1'b0, lb_acc_q});
						q_c[0] = 1'b1;
					end else begin
						a_c = t[LN_W-1:0];
					end
				end
			end
		end
		always_ff @(posedge clk)
			if (en[k]) begin
				a2_s[k]  <= a_c;
				q2_s[k]  <= q_c;
				ovf_s[k] <= ovf_s[k-1];
			end
	end

	// final stage: pick the value, saturate to 1.0, output register
	logic [1:0]       reg_f;
	logic [ONE_W-1:0] vfix_f, rl_f, dr_f;
	logic [VW-1:0]    v_f;
	logic [OW-1:0]    vout_f;
	logic [15:0]      vel_s54;
	logic [1:0]       reg_s54;

	always_comb begin
		{reg_f, vfix_f, rl_f, dr_f} = side_s[N_STG-1];
		if (reg_f != REGION_LOG)
			v_f = VW'(vfix_f);
		else if (lb_acc_q == '0)
			v_f = VW'(rl_f) + VW'(dr_f);
		else if (ovf_s[N_STG-1])
			v_f = VW'(ONE_C);
		else
			v_f = VW'(rl_f) + VW'(q2_s[N_STG-1]);
		if (v_f > VW'(ONE_C))
			v_f = VW'(ONE_C);
		vout_f = OW'(v_f);
	end

	always_ff @(posedge clk)
		if (en[N_STG]) begin
			vel_s54 <= vout_f[15:0];
			reg_s54 <= reg_f;
		end

	assign out_valid      = v_q[N_STG];
	assign velocity_ratio = vel_s54;
	assign region         = reg_s54;

	// checks
	`LRVR_ASSERT_NOW(a_ready_needs_base, in_ready, lb_done, "input taken while base log busy")
	`LRVR_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_ready, "input open right after config write")
	`LRVR_ASSERT_NOW(a_base_mant_norm, lb_state_q == LB_RUN, lb_m_q[30], "base mantissa not normalized")

endmodule
